// ----- hw/rtl/psq_pkg.sv -----
package psq_pkg;

    localparam int TAG_W   = 24;
    localparam int PRIO_W  = 8;
    localparam int BURST_W = 16;
    localparam int TIME_W  = 20;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LIST   = 2'd1;
    localparam logic [1:0] OP_RUN    = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [1:0] ST_JOB   = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic [TAG_W-1:0]   job_tag;
        logic [PRIO_W-1:0]  job_priority;
        logic [BURST_W-1:0] job_burst;
    } in_word_t;

    typedef struct packed {
        logic [TAG_W-1:0]   out_tag;
        logic [PRIO_W-1:0]  out_priority;
        logic [BURST_W-1:0] out_burst;
        logic [TIME_W-1:0]  start_time;
        logic [TIME_W-1:0]  end_time;
        logic [1:0]         status;
        logic               last;
    } out_word_t;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] burst;
    } job_entry_t;

endpackage

// ----- hw/rtl/psq_job_ram.sv -----
module psq_job_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  psq_pkg::job_entry_t wr_data,
    input  logic [AW-1:0]       rd_addr,
    output psq_pkg::job_entry_t rd_data
);
    import psq_pkg::*;

    job_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- hw/rtl/priority_schedule_queue.sv -----
// Channel  Role    Handshake               Word
// job      in      job_valid / job_stall   job_data   (psq_pkg::in_word_t)
// sched    out     sched_valid / sched_stall sched_data (psq_pkg::out_word_t)
//
// Insert: take the word, then read and compare each job moved up behind the new one,
//   then write the new job at the head or where the compare stops, and list the queue.
// List / run: per queued job, a store read, then the time add and output load.
// Refused insert or empty list / run: take the word, then load the status word.
// Reset clears the job count and the handshake state; store contents stay undefined.
// A stalled output word holds the sequencer in place; job_stall is high until the
//   last word of an item is loaded into the output register.
module priority_schedule_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    output logic               job_stall,
    input  psq_pkg::in_word_t  job_data,
    output logic               sched_valid,
    input  logic               sched_stall,
    output psq_pkg::out_word_t sched_data
);
    import psq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_EMIT_RD,
        S_EMIT_LD,
        S_STATUS
    } state_t;

    state_t          state_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   j_reg;
    logic [AW-1:0]   idx_reg;
    logic            run_reg;
    logic            out_valid_reg;
    logic            out_valid_next;

    job_entry_t      new_reg;
    logic [TIME_W-1:0] time_reg;
    logic [1:0]      status_reg;
    out_word_t       out_reg;

    logic            job_accept;
    logic            out_free;
    logic            out_load;
    out_word_t       load_word;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    job_entry_t      wr_data;
    logic [AW-1:0]   rd_addr;
    job_entry_t      rd_data;
    logic            shift_up;
    logic [TIME_W:0] time_sum;
    logic [TIME_W-1:0] end_time;
    logic            is_last;

    assign job_accept  = job_valid && !job_stall;
    assign out_free    = !out_valid_reg || !sched_stall;
    assign out_load    = out_free && (state_reg == S_EMIT_LD || state_reg == S_STATUS);
    assign out_valid_next = out_load || (out_valid_reg && sched_stall);
    assign job_stall   = (state_reg != S_IDLE);
    assign sched_valid = out_valid_reg;
    assign sched_data  = out_reg;

    // new job goes behind every entry with smaller or equal priority
    assign shift_up = (rd_data.prio > new_reg.prio);

    assign time_sum = {1'b0, time_reg} + (TIME_W + 1)'(rd_data.burst);
    assign end_time = time_sum[TIME_W] ? {TIME_W{1'b1}} : time_sum[TIME_W-1:0];
    assign is_last  = ((CW'(idx_reg) + CW'(1)) == count_reg);

    always_comb
    begin
        load_word = '0;
        if (state_reg == S_STATUS)
        begin
            load_word.status = status_reg;
            load_word.last   = 1'b1;
        end
        else
        begin
            load_word.out_tag      = rd_data.tag;
            load_word.out_priority = rd_data.prio;
            load_word.out_burst    = rd_data.burst;
            load_word.start_time   = time_reg;
            load_word.end_time     = end_time;
            load_word.status       = ST_JOB;
            load_word.last         = is_last;
        end
    end

    always_comb
    begin
        if (state_reg == S_INS_RD)
        begin
            rd_addr = AW'(j_reg - CW'(1));
        end
        else
        begin
            rd_addr = idx_reg;
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = AW'(j_reg);
        wr_data = new_reg;
        if (state_reg == S_INS_RD && j_reg == '0)
        begin
            wr_en = 1'b1;
        end
        else if (state_reg == S_INS_CMP)
        begin
            wr_en = 1'b1;
            if (shift_up)
            begin
                wr_data = rd_data;
            end
        end
    end

    psq_job_ram #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_job_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            j_reg         <= '0;
            idx_reg       <= '0;
            run_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (out_load)
            begin
                out_reg <= load_word;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_accept)
                    begin
                        run_reg <= (job_data.operation == OP_RUN);
                        idx_reg <= '0;
                        j_reg   <= count_reg;
                        unique case (job_data.operation)
                            OP_INSERT:
                            begin
                                if (count_reg == CW'(QUEUE_DEPTH))
                                begin
                                    state_reg <= S_STATUS;
                                end
                                else
                                begin
                                    state_reg <= S_INS_RD;
                                end
                            end
                            OP_LIST, OP_RUN:
                            begin
                                if (count_reg == '0)
                                begin
                                    state_reg <= S_STATUS;
                                end
                                else
                                begin
                                    state_reg <= S_EMIT_RD;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_INS_RD:
                begin
                    if (j_reg == '0)
                    begin
                        count_reg <= count_reg + CW'(1);
                        state_reg <= S_EMIT_RD;
                    end
                    else
                    begin
                        state_reg <= S_INS_CMP;
                    end
                end
                S_INS_CMP:
                begin
                    if (shift_up)
                    begin
                        j_reg     <= j_reg - CW'(1);
                        state_reg <= S_INS_RD;
                    end
                    else
                    begin
                        count_reg <= count_reg + CW'(1);
                        state_reg <= S_EMIT_RD;
                    end
                end
                S_EMIT_RD:
                begin
                    state_reg <= S_EMIT_LD;
                end
                S_EMIT_LD:
                begin
                    if (out_free)
                    begin
                        if (is_last)
                        begin
                            state_reg <= S_IDLE;
                            if (run_reg)
                            begin
                                count_reg <= '0;
                            end
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + AW'(1);
                            state_reg <= S_EMIT_RD;
                        end
                    end
                end
                S_STATUS:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && job_accept)
        begin
            new_reg.tag   <= job_data.job_tag;
            new_reg.prio  <= job_data.job_priority;
            new_reg.burst <= job_data.job_burst;
            time_reg      <= '0;
            status_reg    <= (job_data.operation == OP_INSERT) ? ST_FULL : ST_EMPTY;
        end
        else if (state_reg == S_EMIT_LD && out_free)
        begin
            time_reg <= end_time;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("job count above queue depth");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (sched_valid && sched_data.status != ST_JOB) |-> sched_data.last)
        else $error("status word without last");

    a_time_order: assert property (@(posedge clk) disable iff (!rst_n)
        (sched_valid && sched_data.status == ST_JOB)
            |-> (sched_data.end_time >= sched_data.start_time))
        else $error("end time before start time");

    a_busy_after_op: assert property (@(posedge clk) disable iff (!rst_n)
        (job_accept && job_data.operation != OP_NONE) |=> job_stall)
        else $error("operation accepted without sequencer going busy");

    a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT_LD) |-> (CW'(idx_reg) < count_reg))
        else $error("listing index past job count");
`endif

endmodule
